// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocking and reset handling for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition never seen outside reset
`define UER_NEVER(lbl, cond, msg) \
  `UER_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// types and constants of the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned Sensors    = 3;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned SensIdxW   = 2;
  localparam int unsigned EchoW      = 3;
  localparam int unsigned TrigTicksW = 8;
  localparam int unsigned WidthUsW   = CountBits + 1;
  localparam int unsigned CfgAddrW   = 8;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic [CfgAddrW-1:0] {
    CfgTargetSensor = 8'd0,
    CfgTriggerTicks = 8'd1,
    CfgWaitLimit    = 8'd2,
    CfgEchoLimit    = 8'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhTrig = 4'b0010,
    PhWait = 4'b0100,
    PhHigh = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [SensIdxW-1:0]   target_sensor;
    logic [TrigTicksW-1:0] trigger_ticks;
    logic [CountBits-1:0]  wait_limit;
    logic [CountBits-1:0]  echo_limit;
  } uer_cfg_t;

  typedef struct packed {
    logic [WidthUsW-1:0] echo_width_us;
    logic                timed_out;
    logic                done_res;
    logic                busy_res;
    logic [EchoW-1:0]    trigger_lines;
  } uer_res_t;

endpackage

// File: rtl/uer_cfg.sv
// ----------------------------------------------------------------------------
// uer_cfg
// configuration register file, one write per handshake
// ----------------------------------------------------------------------------
module uer_cfg
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output uer_cfg_t            cfg_o
);

  uer_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgTargetSensor: cfg_d.target_sensor = cfg_data_i[SensIdxW-1:0];
        CfgTriggerTicks: cfg_d.trigger_ticks = cfg_data_i[TrigTicksW-1:0];
        CfgWaitLimit:    cfg_d.wait_limit    = cfg_data_i[CountBits-1:0];
        CfgEchoLimit:    cfg_d.echo_limit    = cfg_data_i[CountBits-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_sensor <= '0;
      cfg_q.trigger_ticks <= TrigTicksW'(5);
      cfg_q.wait_limit    <= CountBits'(5000);
      cfg_q.echo_limit    <= CountBits'(65535);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/uer_fsm.sv
// ----------------------------------------------------------------------------
// uer_fsm
// measurement sequencer: trigger, wait for echo, count echo high ticks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uer_fsm
  import uer_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             action_i,
  input  logic [EchoW-1:0] echo_i,
  input  uer_cfg_t         cfg_i,
  output uer_res_t         res_o
);

  phase_e               phase_q, phase_d;
  logic [CountBits-1:0] tick_q, tick_d;
  logic [SensIdxW-1:0]  active_q, active_d;
  logic [CountBits-1:0] width_q, width_d;
  logic                 tmo_q, tmo_d;
  logic                 done;
  logic                 echo_act;
  logic [CountBits-1:0] tick_inc;

  assign tick_inc = tick_q + CountBits'(1);

  always_comb begin
    echo_act = 1'b0;
    for (int k = 0; k < Sensors; k++) begin
      if (active_q == SensIdxW'(k)) begin
        echo_act = echo_i[k];
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    active_d = active_q;
    width_d  = width_q;
    tmo_d    = tmo_q;
    done     = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (action_i) begin
          active_d = cfg_i.target_sensor;
          phase_d  = PhTrig;
          tick_d   = CountBits'(1);
        end
      end
      PhTrig: begin
        if (tick_q >= CountBits'(cfg_i.trigger_ticks)) begin
          phase_d = PhWait;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhWait: begin
        if (echo_act) begin
          phase_d = PhHigh;
          tick_d  = (cfg_i.echo_limit == '0) ? '0 : CountBits'(1);
        end else if (tick_q >= cfg_i.wait_limit) begin
          phase_d = PhIdle;
          tick_d  = '0;
          width_d = '0;
          tmo_d   = 1'b1;
          done    = 1'b1;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhHigh: begin
        if (echo_act) begin
          if (tick_q < cfg_i.echo_limit) begin
            tick_d = tick_inc;
          end
        end else begin
          phase_d = PhIdle;
          width_d = tick_q;
          tmo_d   = 1'b0;
          tick_d  = '0;
          done    = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  always_comb begin
    res_o.trigger_lines = '0;
    for (int k = 0; k < Sensors; k++) begin
      res_o.trigger_lines[k] = (phase_d == PhTrig) && (active_d == SensIdxW'(k));
    end
    res_o.busy_res      = (phase_d != PhIdle);
    res_o.done_res      = done;
    res_o.timed_out     = tmo_d;
    res_o.echo_width_us = {width_d, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      tick_q   <= '0;
      active_q <= '0;
      width_q  <= '0;
      tmo_q    <= 1'b0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      active_q <= active_d;
      width_q  <= width_d;
      tmo_q    <= tmo_d;
    end
  end

  `UER_ASSERT(a_done_idle, adv_i && done |=> phase_q == PhIdle, "finish did not return to idle")
  `UER_NEVER(a_trig_busy, (res_o.trigger_lines != '0) && !res_o.busy_res, "trigger while idle")
  `UER_ASSERT(a_tmo_zero, tmo_q |-> width_q == '0, "timeout with nonzero width")
  `UER_ASSERT(a_trig_hot, $onehot0(res_o.trigger_lines), "more than one trigger line")

endmodule

// File: rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// trigger and echo timing controller for pulse-echo range sensors
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid_i/tready_o  tuser action, tdata echo_lines
// m_axis    out        m_axis_tvalid_o/tready_i  tdata result fields
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_addr_i index, cfg_data_i value
//
// one tick item per cycle sustained while m_axis accepts results; the path from input
// to result runs through the input register, sequencer logic and result register
// each item updates phase and tick counter in a single pass of the sequencer
// a stall on m_axis holds both stages; the input register fills and then
// s_axis_tready_o drops
// reset clears phase, counters and configuration to defaults at once
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [2:0] echo_lines
  input  logic [0:0]          s_axis_tuser_i,   // [0] action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [2:0] trigger_lines, [3] busy_res, [4] done_res, [5] timed_out,
  // [22:6] echo_width_us
  output logic [23:0]         m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  uer_cfg_t         cfg;
  uer_res_t         res;
  logic             in_valid_q;
  logic             in_action_q;
  logic [EchoW-1:0] in_echo_q;
  logic             out_valid_q;
  uer_res_t         out_res_q;
  logic             adv;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  uer_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uer_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .action_i (in_action_q),
    .echo_i   (in_echo_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_action_q <= s_axis_tuser_i[0];
      in_echo_q   <= s_axis_tdata_i[EchoW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q};

endmodule

// File: bench/ultrasonic_echo_ranger_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_test
// self-checking bench for the ultrasonic echo ranger: tick items go in with
// bursty timing, every result item is compared with a cycle model of the
// trigger, wait and echo-count sequencer kept here, under several register
// settings and a receiver that stalls on a pattern of its own
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_test;
  import uer_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomItems = 1000;
  localparam logic        ActTick     = 1'b0;
  localparam logic        ActStart    = 1'b1;

  typedef enum logic [1:0] {RxOpen, RxLight, RxHeavy, RxPeriodic} rx_mode_e;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;   // [2:0] echo_lines
  logic [0:0]          s_axis_tuser_i  = '0;   // [0] action
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [2:0] trigger_lines, [3] busy_res, [4] done_res, [5] timed_out,
  // [22:6] echo_width_us
  logic [23:0]         m_axis_tdata_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  // register copies
  logic [SensIdxW-1:0]   cfg_target = '0;
  logic [TrigTicksW-1:0] cfg_trig   = 8'd5;
  logic [CountBits-1:0]  cfg_wait   = 16'd5000;
  logic [CountBits-1:0]  cfg_echo   = 16'hFFFF;

  // sequencer state of the model
  phase_e               ranger_phase   = PhIdle;
  logic [CountBits-1:0] ranger_count   = '0;
  logic [SensIdxW-1:0]  ranger_sensor  = '0;
  logic [CountBits-1:0] ranger_width   = '0;
  logic                 ranger_timeout = 1'b0;

  uer_res_t    expected_results[$];
  int unsigned error_count = 0;
  int unsigned item_total  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;

  ultrasonic_echo_ranger dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ultrasonic_echo_ranger_test failed");
      $finish;
    end
  end

  // one tick of the sequencer, queues the result item it shows
  task automatic advance_ranger(input logic act, input logic [EchoW-1:0] echo);
    logic     hit;
    logic     finished;
    uer_res_t res;
    hit      = 1'b0;
    finished = 1'b0;
    if (ranger_sensor < Sensors) hit = echo[ranger_sensor];
    case (ranger_phase)
      PhIdle: begin
        if (act == ActStart) begin
          ranger_sensor = cfg_target;
          ranger_phase  = PhTrig;
          ranger_count  = CountBits'(1);
        end
      end
      PhTrig: begin
        if (ranger_count >= cfg_trig) begin
          ranger_phase = PhWait;
          ranger_count = '0;
        end else begin
          ranger_count = ranger_count + 1'b1;
        end
      end
      PhWait: begin
        if (hit) begin
          ranger_phase = PhHigh;
          ranger_count = (cfg_echo == '0) ? '0 : CountBits'(1);
        end else if (ranger_count >= cfg_wait) begin
          ranger_phase   = PhIdle;
          ranger_count   = '0;
          ranger_width   = '0;
          ranger_timeout = 1'b1;
          finished       = 1'b1;
        end else begin
          ranger_count = ranger_count + 1'b1;
        end
      end
      default: begin
        if (hit) begin
          if (ranger_count < cfg_echo) ranger_count = ranger_count + 1'b1;
        end else begin
          ranger_phase   = PhIdle;
          ranger_width   = ranger_count;
          ranger_timeout = 1'b0;
          ranger_count   = '0;
          finished       = 1'b1;
        end
      end
    endcase
    res.trigger_lines = '0;
    if (ranger_phase == PhTrig && ranger_sensor < Sensors)
      res.trigger_lines = EchoW'(1) << ranger_sensor;
    res.busy_res      = (ranger_phase != PhIdle);
    res.done_res      = finished;
    res.timed_out     = ranger_timeout;
    res.echo_width_us = {ranger_width, 1'b0};
    expected_results.push_back(res);
  endtask

  // random echo pins with the measured sensor's pin forced to a level
  function automatic logic [EchoW-1:0] echo_level(input logic level);
    logic [EchoW-1:0] e;
    e = EchoW'($urandom);
    if (ranger_sensor < Sensors) e[ranger_sensor] = level;
    return e;
  endfunction

  task automatic send_tick(input logic act, input logic [EchoW-1:0] echo);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = act;
    s_axis_tdata_i  = 8'(echo);
    do @(posedge clk_i); while (!s_axis_tready_o);
    advance_ranger(act, echo);
    burst_left = burst_left - 1;
    item_total = item_total + 1;
  endtask

  // let every result drain before touching registers or ending
  task automatic quiesce;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    burst_left      = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgTargetSensor: cfg_target = value[SensIdxW-1:0];
      CfgTriggerTicks: cfg_trig   = value[TrigTicksW-1:0];
      CfgWaitLimit:    cfg_wait   = value;
      CfgEchoLimit:    cfg_echo   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // unused upper data bits carry random junk
  task automatic set_config(input logic [SensIdxW-1:0] target,
                            input logic [TrigTicksW-1:0] trig,
                            input logic [CountBits-1:0] wait_ticks,
                            input logic [CountBits-1:0] echo_ticks);
    logic [CfgDataW-1:0] junk;
    quiesce();
    junk = CfgDataW'($urandom);
    write_register(CfgTargetSensor, {junk[CfgDataW-1:SensIdxW], target});
    write_register(CfgTriggerTicks, {junk[CfgDataW-1:TrigTicksW], trig});
    write_register(CfgWaitLimit, wait_ticks);
    write_register(CfgEchoLimit, echo_ticks);
  endtask

  // one measurement: start, trigger, low ticks, high ticks, then echo low
  // until done; jam sends random start requests while busy
  task automatic run_ping(input int unsigned low_ticks, input int unsigned high_ticks,
                          input bit jam);
    int unsigned i;
    send_tick(ActStart, EchoW'($urandom));
    while (ranger_phase == PhTrig)
      send_tick(jam ? 1'($urandom) : ActTick, EchoW'($urandom));
    for (i = 0; i < low_ticks && ranger_phase == PhWait; i++)
      send_tick(jam ? 1'($urandom) : ActTick, echo_level(1'b0));
    for (i = 0; i < high_ticks && ranger_phase != PhIdle; i++)
      send_tick(jam ? 1'($urandom) : ActTick, echo_level(1'b1));
    while (ranger_phase != PhIdle)
      send_tick(jam ? 1'($urandom) : ActTick, echo_level(1'b0));
  endtask

  task automatic test_reset_defaults;
    repeat (3) send_tick(ActTick, EchoW'($urandom));
    run_ping(4, 7, 1'b1);
    run_ping(30, 3, 1'b0);
    run_ping(2, 1, 1'b0);
  endtask

  task automatic test_sensor_select;
    int unsigned s;
    for (s = 0; s < (1 << SensIdxW); s++) begin
      set_config(SensIdxW'(s), 8'd1, 16'd3, 16'd20);
      run_ping(1, 4, 1'b0);
      run_ping(10, 0, 1'b0);
    end
  endtask

  task automatic test_register_extremes;
    set_config(2'd1, 8'd0, 16'd0, 16'd0);
    run_ping(0, 3, 1'b0);
    run_ping(1, 0, 1'b0);
    set_config(2'd2, 8'd255, 16'hFFFF, 16'd1);
    run_ping(20, 5, 1'b1);
    quiesce();
    write_register(CfgAddrW'($urandom_range(CfgEchoLimit + 1, (1 << CfgAddrW) - 1)),
                   CfgDataW'($urandom));
    run_ping(3, 2, 1'b0);
    set_config(2'd0, 8'd2, 16'd1, 16'd3);
    run_ping(0, 20, 1'b1);
  endtask

  task automatic test_long_echo;
    set_config(2'd2, 8'd1, 16'd10, 16'd100);
    run_ping(3, 140, 1'b0);
    run_ping(2, 60, 1'b0);
  endtask

  task automatic test_random;
    int unsigned first_item;
    int unsigned kind;
    int unsigned wait_cap;
    int unsigned echo_cap;
    logic [TrigTicksW-1:0] trig;
    logic [CountBits-1:0]  wait_ticks;
    logic [CountBits-1:0]  echo_ticks;
    first_item = item_total;
    while (item_total - first_item < RandomItems) begin
      trig = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255)
                                         : TrigTicksW'($urandom_range(1, 8));
      wait_ticks = ($urandom_range(0, 9) == 0) ? '0 : CountBits'($urandom_range(1, 24));
      echo_ticks = ($urandom_range(0, 9) == 0) ? '0 : CountBits'($urandom_range(1, 24));
      set_config(($urandom_range(0, 7) == 0) ? 2'd3 : SensIdxW'($urandom_range(0, 2)),
                 trig, wait_ticks, echo_ticks);
      wait_cap = (cfg_wait > 30) ? 30 : cfg_wait + 2;
      echo_cap = (cfg_echo > 30) ? 30 : cfg_echo + 3;
      repeat (12) begin
        repeat ($urandom_range(0, 2)) send_tick(ActTick, EchoW'($urandom));
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(4, 16)) send_tick(1'($urandom), EchoW'($urandom));
          while (ranger_phase != PhIdle) send_tick(ActTick, echo_level(1'b0));
        end else if (kind == 1) begin
          run_ping(70000, 0, 1'($urandom));
        end else begin
          run_ping($urandom_range(0, wait_cap), $urandom_range(0, echo_cap), 1'($urandom));
        end
      end
    end
  endtask

  // receiver stall pattern
  initial begin
    rx_mode_e    mode;
    int unsigned stall_cnt;
    stall_cnt = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(16, 128)) begin
        @(negedge clk_i);
        stall_cnt = stall_cnt + 1;
        case (mode)
          RxOpen:  m_axis_tready_i = 1'b1;
          RxLight: m_axis_tready_i = ($urandom_range(0, 3) != 0);
          RxHeavy: m_axis_tready_i = ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i = (stall_cnt % 3 != 0);
        endcase
      end
    end
  end

  function automatic void compare_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
      error_count = error_count + 1;
    end
  endfunction

  always @(posedge clk_i) begin
    uer_res_t want;
    uer_res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = uer_res_t'(m_axis_tdata_o[$bits(uer_res_t)-1:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none actual %h", $time,
                 m_axis_tdata_o);
        error_count = error_count + 1;
      end else begin
        want = expected_results.pop_front();
        compare_field("trigger_lines", want.trigger_lines, got.trigger_lines);
        compare_field("busy_res", want.busy_res, got.busy_res);
        compare_field("done_res", want.done_res, got.done_res);
        compare_field("timed_out", want.timed_out, got.timed_out);
        compare_field("echo_width_us", want.echo_width_us, got.echo_width_us);
        compare_field("tdata padding", 0, m_axis_tdata_o[23]);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_sensor_select();
    test_register_extremes();
    test_long_echo();
    test_random();
    quiesce();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ultrasonic_echo_ranger_test passed");
    end else begin
      $display("ultrasonic_echo_ranger_test failed");
    end
    $finish;
  end

endmodule
